// ===== rtl/kpi_pkg.sv =====
package kpi_pkg;

    localparam int TIME_W   = 18;
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;
    localparam int COLOR_W  = NUM_CH * CH_W;
    localparam int CFG_W    = 6;
    localparam int KIDX_W   = 5;
    localparam int SLOT_W   = 3;
    localparam int FRAC_SH  = 16;
    localparam int DVD_W    = TIME_W + FRAC_SH;
    localparam int FRAC_W   = DVD_W + 2;
    localparam int DIFF_W   = CH_W + 1;
    localparam int PROD_W   = FRAC_W + DIFF_W;
    localparam int SHP_W    = PROD_W - FRAC_SH;
    localparam int SUM_W    = SHP_W + 1;
    localparam int DCNT_W   = $clog2(DVD_W + 1);

    localparam logic [CFG_W-1:0] KEYS_RST = 6'd26;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_NEIGH,
        S_SPAN,
        S_DIV,
        S_RD_LO,
        S_RD_HI,
        S_MUL,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [TIME_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DVD_W-1:0]  quo;
        logic [TIME_W-1:0] rem;
    } div_rsp_t;

endpackage

// ===== rtl/keyframe_palette_interpolator_top.sv =====
// Keyframe palette interpolator. A load writes one keyframe time plus one slot color.
// A query scans keys_in_use time entries through the single time-memory read port, runs
// a 34-step serial divider for the fraction, then produces each of the SLOTS colors in
// turn: color-memory reads of both neighbour keys (one read on an exact hit or zero span),
// multiply, and output, which waits while the output stalls. Exact hits and zero spans
// skip the divider. Input stalls while a query is in progress; the last result may still
// sit in the output register when the next request is taken.
module keyframe_palette_interpolator_top
#(
    parameter int MAX_KEYS = 32,
    parameter int SLOTS    = 5
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kpi_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [kpi_pkg::KIDX_W-1:0]    key_index,
    input  logic [kpi_pkg::SLOT_W-1:0]    slot,
    input  logic [kpi_pkg::TIME_W-1:0]    key_time,
    input  logic [kpi_pkg::CH_W-1:0]      red_in,
    input  logic [kpi_pkg::CH_W-1:0]      green_in,
    input  logic [kpi_pkg::CH_W-1:0]      blue_in,
    input  logic [kpi_pkg::TIME_W-1:0]    query_time,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [kpi_pkg::SLOT_W-1:0]    out_slot,
    output logic [kpi_pkg::CH_W-1:0]      red_out,
    output logic [kpi_pkg::CH_W-1:0]      green_out,
    output logic [kpi_pkg::CH_W-1:0]      blue_out,
    output logic                          exact_hit,
    output logic                          zero_span,
    output logic                          last_slot
);
    import kpi_pkg::*;

    localparam int KW    = $clog2(MAX_KEYS);
    localparam int NW    = $clog2(MAX_KEYS + 1);
    localparam int SIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CDEP  = MAX_KEYS * SLOTS;
    localparam int CAW   = $clog2(CDEP);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]   keys_reg;
    logic [NW-1:0]      n_eff;
    logic [NW-1:0]      n_reg;
    logic [NW-1:0]      cnt_reg;
    logic               pend_reg;
    logic [KW-1:0]      pidx_reg;
    logic [TIME_W-1:0]  q_reg;
    logic [TIME_W-1:0]  best_reg;
    logic [TIME_W-1:0]  tc_reg;
    logic [KW-1:0]      c_reg;
    logic [KW-1:0]      lo_reg;
    logic [KW-1:0]      hi_reg;
    logic               gt_reg;
    logic               raw_reg;
    logic               exact_reg;
    logic               zero_reg;
    logic               neg_reg;
    logic [CAW-1:0]     row_lo_reg;
    logic [CAW-1:0]     row_hi_reg;
    logic [SIW-1:0]     si_reg;
    logic signed [FRAC_W-1:0] frac_reg;
    logic [COLOR_W-1:0] c1_reg;
    logic signed [PROD_W-1:0] prod_reg [NUM_CH];

    logic [TIME_W-1:0]  tmem [MAX_KEYS];
    logic [COLOR_W-1:0] cmem [CDEP];
    logic [TIME_W-1:0]  times_q;
    logic [COLOR_W-1:0] col_q;
    logic [KW-1:0]      t_raddr;
    logic [CAW-1:0]     c_raddr;

    logic               out_valid_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [COLOR_W-1:0] out_col_reg;
    logic               out_exact_reg;
    logic               out_zero_reg;
    logic               out_last_reg;
    logic               out_free;

    logic               acc;
    logic               t_we;
    logic               c_we;
    logic [CAW-1:0]     c_waddr;
    logic [TIME_W-1:0]  tdist;
    logic [TIME_W-1:0]  tlo;
    logic [TIME_W-1:0]  thi;
    logic [TIME_W-1:0]  base;
    logic [TIME_W-1:0]  span;
    logic signed [TIME_W:0] num;
    logic [TIME_W-1:0]  num_mag;
    logic [KW-1:0]      lo_n;
    logic [KW-1:0]      hi_n;
    logic               tgt;
    logic               last_i;
    logic signed [FRAC_W-1:0] qext;
    logic [COLOR_W-1:0] lerp_col;

    div_req_t dreq;
    div_rsp_t drsp;

    kpi_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign acc       = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_i    = (int'(si_reg) == SLOTS - 1);

    always_comb
    begin
        if (keys_reg == '0)
            n_eff = NW'(1);
        else if (int'(keys_reg) > MAX_KEYS)
            n_eff = NW'(MAX_KEYS);
        else
            n_eff = NW'(keys_reg);
    end

    assign t_we    = acc && (operation == OP_LOAD) && (int'(key_index) < MAX_KEYS);
    assign c_we    = t_we && (int'(slot) < SLOTS);
    assign c_waddr = CAW'(int'(key_index) * SLOTS + int'(slot));

    assign tgt  = tc_reg > q_reg;
    assign lo_n = (c_reg == '0) ? KW'(n_reg - 1'b1) : c_reg - 1'b1;
    assign hi_n = (NW'(c_reg) + 1'b1 >= n_reg) ? '0 : c_reg + 1'b1;

    always_comb
    begin
        t_raddr = cnt_reg[KW-1:0];
        if (state_reg == S_NEIGH)
            t_raddr = tgt ? lo_n : hi_n;
    end

    always_comb
    begin
        c_raddr = row_lo_reg + CAW'(si_reg);
        if (state_reg == S_RD_HI)
            c_raddr = row_hi_reg + CAW'(si_reg);
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
            tmem[KW'(key_index)] <= key_time;
        times_q <= tmem[t_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
            cmem[c_waddr] <= {red_in, green_in, blue_in};
        col_q <= cmem[c_raddr];
    end

    assign tdist = (times_q > q_reg) ? times_q - q_reg : q_reg - times_q;
    assign tlo  = gt_reg ? times_q : tc_reg;
    assign thi  = gt_reg ? tc_reg : times_q;
    assign base = (tlo <= thi) ? tlo : thi;
    assign span = (tlo <= thi) ? thi - tlo : tlo - thi;
    assign num  = $signed({1'b0, q_reg}) - $signed({1'b0, base});
    assign num_mag = num[TIME_W] ? TIME_W'(-num) : num[TIME_W-1:0];

    assign dreq.start    = (state_reg == S_SPAN) && (span != '0);
    assign dreq.dividend = {num_mag, {FRAC_SH{1'b0}}};
    assign dreq.divisor  = span;

    assign qext = $signed({2'b00, drsp.quo});

    always_comb
    begin
        logic [CH_W-1:0]          c1;
        logic signed [SUM_W-1:0]  v;
        lerp_col = '0;
        for (int k = 0; k < NUM_CH; k++)
        begin
            c1 = c1_reg[k*CH_W +: CH_W];
            v  = $signed({{(SUM_W-CH_W){1'b0}}, c1})
               + SUM_W'($signed(prod_reg[k][PROD_W-1:FRAC_SH]));
            if (v < 0)
                lerp_col[k*CH_W +: CH_W] = '0;
            else if (v > $signed(SUM_W'(255)))
                lerp_col[k*CH_W +: CH_W] = '1;
            else
                lerp_col[k*CH_W +: CH_W] = v[CH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc && operation == OP_QUERY)
                    state_next = S_SRCH;
            end
            S_SRCH:
            begin
                if (cnt_reg >= n_reg && !pend_reg)
                    state_next = S_NEIGH;
            end
            S_NEIGH:
            begin
                if (tc_reg == q_reg)
                    state_next = S_RD_LO;
                else
                    state_next = S_SPAN;
            end
            S_SPAN:
            begin
                if (span == '0)
                    state_next = S_RD_LO;
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (drsp.done)
                    state_next = S_RD_LO;
            end
            S_RD_LO:
            begin
                state_next = raw_reg ? S_MUL : S_RD_HI;
            end
            S_RD_HI:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                    state_next = last_i ? S_IDLE : S_RD_LO;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keys_reg <= KEYS_RST;
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            si_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                keys_reg <= cfg_data;
            if (state_reg == S_IDLE)
            begin
                cnt_reg  <= '0;
                pend_reg <= 1'b0;
                si_reg   <= '0;
            end
            else if (state_reg == S_SRCH)
            begin
                pend_reg <= cnt_reg < n_reg;
                if (cnt_reg < n_reg)
                    cnt_reg <= cnt_reg + 1'b1;
            end
            else if (state_reg == S_EMIT && out_free)
                si_reg <= si_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                q_reg     <= query_time;
                n_reg     <= n_eff;
                exact_reg <= 1'b0;
                zero_reg  <= 1'b0;
                raw_reg   <= 1'b0;
            end
            S_SRCH:
            begin
                pidx_reg <= cnt_reg[KW-1:0];
                if (pend_reg && (pidx_reg == '0 || tdist < best_reg))
                begin
                    best_reg <= tdist;
                    tc_reg   <= times_q;
                    c_reg    <= pidx_reg;
                end
            end
            S_NEIGH:
            begin
                gt_reg <= tgt;
                lo_reg <= tgt ? lo_n : c_reg;
                hi_reg <= tgt ? c_reg : hi_n;
                if (tc_reg == q_reg)
                begin
                    exact_reg  <= 1'b1;
                    raw_reg    <= 1'b1;
                    row_lo_reg <= CAW'(int'(c_reg) * SLOTS);
                end
            end
            S_SPAN:
            begin
                row_lo_reg <= CAW'(int'(lo_reg) * SLOTS);
                row_hi_reg <= CAW'(int'(hi_reg) * SLOTS);
                neg_reg    <= num[TIME_W];
                if (span == '0)
                begin
                    zero_reg <= 1'b1;
                    raw_reg  <= 1'b1;
                end
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    // floor for negative numerator
                    if (!neg_reg)
                        frac_reg <= qext;
                    else if (drsp.rem != '0)
                        frac_reg <= -qext - 1'b1;
                    else
                        frac_reg <= -qext;
                end
            end
            S_RD_HI:
            begin
                c1_reg <= col_q;
            end
            S_MUL:
            begin
                if (raw_reg)
                    c1_reg <= col_q;
                for (int k = 0; k < NUM_CH; k++)
                begin
                    prod_reg[k] <= ($signed({1'b0, col_q[k*CH_W +: CH_W]})
                                 - $signed({1'b0, c1_reg[k*CH_W +: CH_W]})) * frac_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_EMIT && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EMIT && out_free)
        begin
            out_slot_reg  <= SLOT_W'(si_reg);
            out_col_reg   <= raw_reg ? c1_reg : lerp_col;
            out_exact_reg <= exact_reg;
            out_zero_reg  <= zero_reg;
            out_last_reg  <= last_i;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_slot  = out_slot_reg;
    assign red_out   = out_col_reg[2*CH_W +: CH_W];
    assign green_out = out_col_reg[CH_W +: CH_W];
    assign blue_out  = out_col_reg[0 +: CH_W];
    assign exact_hit = out_exact_reg;
    assign zero_span = out_zero_reg;
    assign last_slot = out_last_reg;

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(exact_hit && zero_span))
        else $error("exact and zero span both set");

    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> state_reg == S_DIV)
        else $error("divider finished outside divide phase");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        dreq.start |=> state_reg == S_DIV)
        else $error("divider started without divide phase");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free && last_i) |=> out_valid && last_slot
            && state_reg == S_IDLE)
        else $error("last result not flagged");

endmodule

// ===== rtl/kpi_div.sv =====
module kpi_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  kpi_pkg::div_req_t req,
    output kpi_pkg::div_rsp_t rsp
);
    import kpi_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [DCNT_W-1:0]   cnt_reg;
    logic [DVD_W-1:0]    quo_reg;
    logic [TIME_W-1:0]   rem_reg;
    logic [TIME_W-1:0]   div_reg;
    logic [TIME_W:0]     trial;
    logic                fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            div_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            if (fits)
                rem_reg <= TIME_W'(trial - {1'b0, div_reg});
            else
                rem_reg <= trial[TIME_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule
